### hdl/cfpp_pkg.sv
// cfpp_pkg: shared types and constants for the colon-field packet parser
// used by cfpp_in_stage, cfpp_parse and colon_field_packet_parser_core
package cfpp_pkg;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int TYPE_W = 8;
  localparam int LEN_W  = 11;

  // parameter defaults
  localparam int NAME_LIMIT_DEF   = 32;
  localparam int DATA_LIMIT_DEF   = 1024;
  localparam int BUFFER_BYTES_DEF = 1250;

  // separator character
  localparam logic [BYTE_W-1:0] SEP_CHAR = 8'h3A;

  // saturation point of the type value
  localparam int TYPE_MAX = 255;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_SRC_BYTE = 2'd1,
    KIND_SRC_END  = 2'd2,
    KIND_DATA     = 2'd3
  } cfpp_kind_t;

  // one input word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first;
  } cfpp_item_t;

  // one result word
  typedef struct packed {
    cfpp_kind_t        kind;
    logic [TYPE_W-1:0] type_code;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              overrun;
  } cfpp_result_t;

endpackage

### hdl/cfpp_in_stage.sv
// cfpp_in_stage: input register of the parser, one word deep
// depends on cfpp_pkg for the input word type
module cfpp_in_stage
  import cfpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cfpp_item_t up_item,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cfpp_item_t dn_item
);

  logic       vld_r;
  logic       vld_nxt;
  cfpp_item_t item_r;

  // take a new word when empty or when the held word moves on
  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = vld_r;
  assign dn_item  = item_r;

endmodule

### hdl/cfpp_parse.sv
// cfpp_parse: parse state, per-word field decode and the result register
// depends on cfpp_pkg for word types, kinds and field widths
module cfpp_parse
  import cfpp_pkg::*;
#(
  parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
  parameter int DATA_LIMIT   = DATA_LIMIT_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  cfpp_item_t   in_item,
  output logic         res_valid,
  input  logic         res_ready,
  output cfpp_result_t res
);

  localparam int NC_W  = $clog2(NAME_LIMIT + 1);
  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [NC_W-1:0]  NAME_LIM = NC_W'(NAME_LIMIT);
  localparam logic [POS_W-1:0] BUF_LIM  = POS_W'(BUFFER_BYTES);
  localparam logic [13:0]      DATA_LIM = 14'(DATA_LIMIT);
  localparam logic [11:0]      TYPE_LIM = 12'(TYPE_MAX);

  typedef enum logic [2:0] {
    F_TYPE   = 3'd0,
    F_SIZE   = 3'd1,
    F_SOURCE = 3'd2,
    F_DATA   = 3'd3,
    F_DONE   = 3'd4
  } field_t;

  field_t            field_r, field_nxt, field_cur;
  logic [TYPE_W-1:0] type_r, type_nxt, type_cur;
  logic              type_stop_r, type_stop_nxt, type_stop_cur;
  logic [LEN_W-1:0]  size_r, size_nxt, size_cur;
  logic              size_stop_r, size_stop_nxt, size_stop_cur;
  logic [NC_W-1:0]   name_cnt_r, name_cnt_nxt, name_cnt_cur;
  logic [LEN_W-1:0]  remain_r, remain_nxt, remain_cur, remain_dec;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_cur;

  logic              res_vld_r, res_vld_nxt;
  cfpp_result_t      res_r, res_nxt;
  logic              emit;
  logic              take;

  logic [BYTE_W-1:0] b;
  logic              is_digit;
  logic              is_sep;
  logic [3:0]        digit;
  logic [11:0]       type_acc;
  logic [13:0]       size_acc;

  // a word moves in when the result register is free or being drained
  assign in_ready = !res_vld_r || res_ready;
  assign take     = in_valid && in_ready;

  assign b        = in_item.data_byte;
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_sep   = (b == SEP_CHAR);
  assign digit    = b[3:0];

  // start flag clears the parse before the byte is used
  always_comb begin
    if (in_item.first) begin
      field_cur     = F_TYPE;
      type_cur      = '0;
      type_stop_cur = 1'b0;
      size_cur      = '0;
      size_stop_cur = 1'b0;
      name_cnt_cur  = '0;
      remain_cur    = '0;
      pos_cur       = '0;
    end else begin
      field_cur     = field_r;
      type_cur      = type_r;
      type_stop_cur = type_stop_r;
      size_cur      = size_r;
      size_stop_cur = size_stop_r;
      name_cnt_cur  = name_cnt_r;
      remain_cur    = remain_r;
      pos_cur       = pos_r;
    end
  end

  // multiply by ten as two shifts and an add
  assign type_acc   = ({4'd0, type_cur} << 3) + ({4'd0, type_cur} << 1) + {8'd0, digit};
  assign size_acc   = ({3'd0, size_cur} << 3) + ({3'd0, size_cur} << 1) + {10'd0, digit};
  assign remain_dec = remain_cur - LEN_W'(1);

  // field decode
  always_comb begin
    field_nxt     = field_cur;
    type_nxt      = type_cur;
    type_stop_nxt = type_stop_cur;
    size_nxt      = size_cur;
    size_stop_nxt = size_stop_cur;
    name_cnt_nxt  = name_cnt_cur;
    remain_nxt    = remain_cur;
    pos_nxt       = pos_cur;
    emit          = 1'b0;
    res_nxt       = '{kind: KIND_HEADER, type_code: '0, length: '0,
                      value: '0, last: 1'b0, overrun: 1'b0};
    if (pos_cur < BUF_LIM) begin
      pos_nxt = pos_cur + POS_W'(1);
      unique case (field_cur)
        F_TYPE: begin
          if (is_sep) begin
            field_nxt = F_SIZE;
          end else if (!type_stop_cur) begin
            if (is_digit) begin
              type_nxt = (type_acc > TYPE_LIM) ? TYPE_LIM[TYPE_W-1:0] : type_acc[TYPE_W-1:0];
            end else begin
              type_stop_nxt = 1'b1;
            end
          end
        end
        F_SIZE: begin
          if (is_sep) begin
            field_nxt         = F_SOURCE;
            emit              = 1'b1;
            res_nxt.kind      = KIND_HEADER;
            res_nxt.type_code = type_cur;
            res_nxt.length    = size_cur;
          end else if (!size_stop_cur) begin
            if (is_digit) begin
              size_nxt = (size_acc > DATA_LIM) ? DATA_LIM[LEN_W-1:0] : size_acc[LEN_W-1:0];
            end else begin
              size_stop_nxt = 1'b1;
            end
          end
        end
        F_SOURCE: begin
          emit = 1'b1;
          if (is_sep) begin
            remain_nxt   = size_cur;
            field_nxt    = (size_cur == '0) ? F_DONE : F_DATA;
            res_nxt.kind = KIND_SRC_END;
            res_nxt.last = (size_cur == '0);
          end else begin
            res_nxt.kind  = KIND_SRC_BYTE;
            res_nxt.value = b;
            if (name_cnt_cur < NAME_LIM) begin
              name_cnt_nxt = name_cnt_cur + NC_W'(1);
            end else begin
              res_nxt.overrun = 1'b1;
            end
          end
        end
        F_DATA: begin
          if (remain_cur == '0) begin
            field_nxt = F_DONE;
          end else begin
            remain_nxt    = remain_dec;
            emit          = 1'b1;
            res_nxt.kind  = KIND_DATA;
            res_nxt.value = b;
            res_nxt.last  = (remain_dec == '0);
            if (remain_dec == '0) begin
              field_nxt = F_DONE;
            end
          end
        end
        default: begin
          field_nxt = field_cur;
        end
      endcase
    end
  end

  // result valid follows the drain and fill of the result register
  always_comb begin
    if (take) begin
      res_vld_nxt = emit;
    end else if (res_ready) begin
      res_vld_nxt = 1'b0;
    end else begin
      res_vld_nxt = res_vld_r;
    end
  end

  // parse state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r     <= F_TYPE;
      type_r      <= '0;
      type_stop_r <= 1'b0;
      size_r      <= '0;
      size_stop_r <= 1'b0;
      name_cnt_r  <= '0;
      remain_r    <= '0;
      pos_r       <= '0;
      res_vld_r   <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (take) begin
        field_r     <= field_nxt;
        type_r      <= type_nxt;
        type_stop_r <= type_stop_nxt;
        size_r      <= size_nxt;
        size_stop_r <= size_stop_nxt;
        name_cnt_r  <= name_cnt_nxt;
        remain_r    <= remain_nxt;
        pos_r       <= pos_nxt;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

endmodule

### hdl/colon_field_packet_parser_core.sv
// Colon-field packet parser: type:size:source:data, one byte per word.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless out_tready stalls; the two registers
// sit on either side of the combinational decode, so both sides stream.
// Reset: rst_n synchronous, active low; clears the parse state and both
// valid flags, parsing resumes as if a packet had begun.
module colon_field_packet_parser_core
  import cfpp_pkg::*;
#(
  parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
  parameter int DATA_LIMIT   = DATA_LIMIT_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] type_code, [18:8] length, [26:19] value, zero fill
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] overrun
  output logic        out_tlast
);

  cfpp_item_t   up_item;
  cfpp_item_t   st_item;
  logic         st_valid;
  logic         st_ready;
  cfpp_result_t res;

  assign up_item.data_byte = in_tdata;
  assign up_item.first     = in_tuser;

  // input register
  cfpp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (up_item),
    .dn_valid (st_valid),
    .dn_ready (st_ready),
    .dn_item  (st_item)
  );

  // decode and result register
  cfpp_parse #(
    .NAME_LIMIT   (NAME_LIMIT),
    .DATA_LIMIT   (DATA_LIMIT),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid),
    .in_ready  (st_ready),
    .in_item   (st_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result word
  assign out_tdata = {5'd0, res.value, res.length, res.type_code};
  assign out_tuser = {res.overrun, res.kind};
  assign out_tlast = res.last;

endmodule

### verif/testbench.sv
// testbench: self-checking bench for colon_field_packet_parser_core
// drives type:size:source:data packets, predicts every result word, needs cfpp_pkg
module testbench
  import cfpp_pkg::*;
;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 120;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;

  // parse position of the predictor
  typedef enum logic [2:0] {
    FLD_TYPE   = 3'd0,
    FLD_SIZE   = 3'd1,
    FLD_SOURCE = 3'd2,
    FLD_DATA   = 3'd3,
    FLD_DONE   = 3'd4
  } field_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] first
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [7:0] type_code, [18:8] length, [26:19] value, zero fill
  logic [2:0]  out_tuser;  // [1:0] kind, [2] overrun
  logic        out_tlast;

  // predictor state
  field_t      field_idx;
  logic [7:0]  type_val;
  logic        type_stop;
  logic [10:0] size_val;
  logic        size_stop;
  logic [5:0]  name_cnt;
  logic [10:0] data_left;
  logic [10:0] byte_pos;

  cfpp_result_t expected_results[$];
  logic [7:0]   pkt_buf[$];
  int           error_count = 0;
  int           parsed_words = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 35;
  int           rx_idle_pct = 35;
  int           hold_left = 0;

  colon_field_packet_parser_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------
  task automatic clear_parse();
    field_idx = FLD_TYPE;
    type_val  = '0;
    type_stop = 1'b0;
    size_val  = '0;
    size_stop = 1'b0;
    name_cnt  = '0;
    data_left = '0;
    byte_pos  = '0;
  endtask

  // decimal accumulate with saturation
  function automatic int sat_accumulate(input int acc, input int digit, input int limit);
    int next;
    next = acc * 10 + digit;
    return (next > limit) ? limit : next;
  endfunction

  task automatic predict_word(input logic [7:0] b, input logic f);
    cfpp_result_t r;
    bit is_digit;
    bit is_sep;
    bit has;
    is_digit = (b >= DIGIT_0) && (b <= DIGIT_9);
    is_sep   = (b == SEP_CHAR);
    has      = 1'b0;
    r        = '0;
    if (f) clear_parse();
    // bytes at or past the buffer end are dropped
    if (byte_pos >= BUFFER_BYTES_DEF) return;
    byte_pos++;
    if (field_idx != FLD_DONE) parsed_words++;
    case (field_idx)
      FLD_TYPE: begin
        if (is_sep) begin
          field_idx = FLD_SIZE;
        end else if (!type_stop) begin
          if (is_digit) type_val = 8'(sat_accumulate(int'(type_val),
                                                     int'(b) - int'(DIGIT_0), TYPE_MAX));
          else type_stop = 1'b1;
        end
      end
      FLD_SIZE: begin
        if (is_sep) begin
          field_idx   = FLD_SOURCE;
          r.kind      = KIND_HEADER;
          r.type_code = type_val;
          r.length    = size_val;
          has         = 1'b1;
        end else if (!size_stop) begin
          if (is_digit) size_val = 11'(sat_accumulate(int'(size_val),
                                                      int'(b) - int'(DIGIT_0),
                                                      DATA_LIMIT_DEF));
          else size_stop = 1'b1;
        end
      end
      FLD_SOURCE: begin
        has = 1'b1;
        if (is_sep) begin
          data_left = size_val;
          field_idx = (size_val == 0) ? FLD_DONE : FLD_DATA;
          r.kind    = KIND_SRC_END;
          r.last    = (size_val == 0);
        end else begin
          r.kind  = KIND_SRC_BYTE;
          r.value = b;
          if (name_cnt < NAME_LIMIT_DEF) name_cnt++;
          else r.overrun = 1'b1;
        end
      end
      FLD_DATA: begin
        if (data_left == 0) begin
          field_idx = FLD_DONE;
        end else begin
          data_left--;
          if (data_left == 0) field_idx = FLD_DONE;
          r.kind  = KIND_DATA;
          r.value = b;
          r.last  = (data_left == 0);
          has     = 1'b1;
        end
      end
      default: ;
    endcase
    if (has) expected_results.push_back(r);
  endtask

  // -------------------------------------------------------------------
  // result checking
  // -------------------------------------------------------------------
  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    cfpp_result_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result word, expected none, actual tdata=%h tuser=%h",
               $time, out_tdata, out_tuser);
    end else begin
      want = expected_results.pop_front();
      compare_field("kind", want.kind, out_tuser[1:0]);
      compare_field("type_code", want.type_code, out_tdata[7:0]);
      compare_field("length", want.length, out_tdata[18:8]);
      compare_field("value", want.value, out_tdata[26:19]);
      compare_field("last", want.last, out_tlast);
      compare_field("overrun", want.overrun, out_tuser[2]);
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_word(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // receiver: random stalls, plus long hold-off when requested
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic f);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit with_first);
    for (int i = 0; i < s.len(); i++) send_word(s[i], with_first && (i == 0));
  endtask

  task automatic send_buffer(input bit with_first, input int keep);
    for (int i = 0; i < keep; i++) send_word(pkt_buf[i], with_first && (i == 0));
  endtask

  // any byte that is neither a digit nor a colon
  function automatic logic [7:0] random_non_digit();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b >= DIGIT_0 && b <= SEP_CHAR) b = b ^ 8'h80;
    return b;
  endfunction

  // any byte but a colon
  function automatic logic [7:0] random_name_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == SEP_CHAR) b = b ^ 8'h80;
    return b;
  endfunction

  // decimal digits of n, optionally with a stray non-digit inside
  task automatic push_number(input int n, input bit break_it);
    string s;
    int pos;
    s   = $sformatf("%0d", n);
    pos = $urandom_range(s.len());
    for (int i = 0; i <= s.len(); i++) begin
      if (break_it && i == pos) pkt_buf.push_back(random_non_digit());
      if (i < s.len()) pkt_buf.push_back(s[i]);
    end
  endtask

  // one random packet, mostly well formed, sometimes noise or cut short
  task automatic random_packet();
    int pick;
    int type_num;
    int size_num;
    int name_len;
    int data_len;
    int keep;
    pkt_buf.delete();
    pick = $urandom_range(99);
    // plain noise
    if (pick < 6) begin
      repeat ($urandom_range(10, 1)) begin
        if ($urandom_range(3) == 0) pkt_buf.push_back(SEP_CHAR);
        else pkt_buf.push_back(8'($urandom_range(255)));
      end
      send_buffer($urandom_range(1) == 1, pkt_buf.size());
      return;
    end
    case ($urandom_range(3))
      0: type_num = $urandom_range(9);
      1: type_num = $urandom_range(255);
      2: type_num = $urandom_range(99999, 256);
      default: type_num = $urandom_range(999);
    endcase
    push_number(type_num, $urandom_range(9) == 0);
    pkt_buf.push_back(SEP_CHAR);
    pick = $urandom_range(99);
    if (pick < 70) size_num = $urandom_range(12);
    else if (pick < 97) size_num = $urandom_range(64, 13);
    else size_num = $urandom_range(99999, 1000);
    push_number(size_num, $urandom_range(9) == 0);
    pkt_buf.push_back(SEP_CHAR);
    pick = $urandom_range(99);
    if (pick < 75) name_len = $urandom_range(6);
    else if (pick < 95) name_len = $urandom_range(31, 7);
    else name_len = $urandom_range(40, 32);
    repeat (name_len) pkt_buf.push_back(random_name_byte());
    pkt_buf.push_back(SEP_CHAR);
    // large sizes only get a short tail so the next packet interrupts them
    data_len = (size_num > 64) ? $urandom_range(20) : size_num;
    repeat (data_len) pkt_buf.push_back(8'($urandom_range(255)));
    repeat ($urandom_range(3)) pkt_buf.push_back(8'($urandom_range(255)));
    keep = pkt_buf.size();
    if ($urandom_range(99) < 12) keep = $urandom_range(pkt_buf.size(), 1);
    send_buffer($urandom_range(99) < 95, keep);
  endtask

  // -------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------

  // parse starts without a start flag after reset, empty source name
  task automatic test_reset_no_start();
    send_text("9:1::Z", 1'b0);
  endtask

  // type and size saturate
  task automatic test_saturation();
    send_text("999:5000:", 1'b1);
  endtask

  // signs and letters stop the numbers, nul and colon in the fields
  task automatic test_non_digit_fields();
    send_text("-1:3x7:", 1'b1);
    send_word(8'h00, 1'b0);
    send_word(SEP_CHAR, 1'b0);
    send_word(SEP_CHAR, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
  endtask

  // zero length ends at the source end, trailing byte ignored
  task automatic test_zero_length();
    send_text("0:0:s:x", 1'b1);
  endtask

  // back to back on both sides
  task automatic test_streaming();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (12) random_packet();
    tx_idle_pct = 35;
    rx_idle_pct = 35;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_hold();
    tx_idle_pct = 0;
    hold_left   = 80;
    pkt_buf.delete();
    push_number(42, 1'b0);
    pkt_buf.push_back(SEP_CHAR);
    push_number(20, 1'b0);
    pkt_buf.push_back(SEP_CHAR);
    repeat (40) pkt_buf.push_back(random_name_byte());
    pkt_buf.push_back(SEP_CHAR);
    repeat (20) pkt_buf.push_back(8'($urandom_range(255)));
    send_buffer(1'b1, pkt_buf.size());
    tx_idle_pct = 35;
  endtask

  // long name overruns and the data runs into the buffer end
  task automatic test_buffer_end();
    pkt_buf.delete();
    send_text("1:99999:", 1'b1);
    repeat (240) pkt_buf.push_back(random_name_byte());
    pkt_buf.push_back(SEP_CHAR);
    repeat (BUFFER_BYTES_DEF - 220) pkt_buf.push_back(8'($urandom_range(255)));
    send_buffer(1'b0, pkt_buf.size());
  endtask

  task automatic test_random_packets();
    int start;
    start = parsed_words;
    while (parsed_words - start < RANDOM_WORDS) random_packet();
  endtask

  // -------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    clear_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_no_start();
    test_saturation();
    test_non_digit_fields();
    test_zero_length();
    test_streaming();
    test_output_hold();
    test_buffer_end();
    test_random_packets();

    // drain
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      $display("%0t: result words missing, expected %0d more, actual 0",
               $time, expected_results.size());
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
